FILE: rtl/cpm_pkg.sv
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared types and codes for the coincident point merger.
// ----------------------------------------------------------------------------
`default_nettype none

package cpm_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_COORD_BITS = 32;

  localparam int SLOT_W  = 10;
  localparam int COORD_W = 32;
  localparam int COUNT_W = 11;
  localparam int TOL_W   = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP      = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      referenced;
    logic                      final_point;
  } in_item_t;

  typedef struct packed {
    logic               answer_kind;
    logic [SLOT_W-1:0]  mapped_index;
    logic               mapped_valid;
    logic [SLOT_W-1:0]  representative;
    logic               representative_valid;
    logic [COUNT_W-1:0] surviving_count;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/cpm_ram.sv
// ----------------------------------------------------------------------------
// cpm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/coincident_point_merger_core.sv
// ----------------------------------------------------------------------------
// coincident_point_merger_core
// Welds points within a squared distance tolerance, compacts the survivors
// and answers index queries from the resulting tables.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | cpm_pkg::in_item_t
//  out_    | output    | out_valid/out_stall| cpm_pkg::out_item_t
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  A load without final_point is written in S_IDLE. A query reads the RAMs, then
//  answers from S_QRESP. A final load runs a clear sweep over MAX_POINTS entries,
//  then the pairwise pass with a target map rescan per merge, an optional drop
//  scan and a per-point compaction.
//  Reset (rst_n, synchronous) clears control state and the result counts.
//  in_stall is high whenever a transaction is in work; a result waits in the
//  output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module coincident_point_merger_core #(
  parameter int MAX_POINTS = cpm_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = cpm_pkg::DEF_COORD_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire cpm_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output cpm_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cpm_pkg::TOL_W-1:0]     cfg_data
);

  import cpm_pkg::*;

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int CB   = COORD_BITS;
  localparam int CRW  = 3 * CB + 1;
  localparam int SQW  = 2 * CB + 2;
  localparam int SUMW = SQW + 2;
  localparam int CMPW = (SUMW > TOL_W) ? SUMW : TOL_W;
  localparam int GW   = IW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_QRESP, S_INIT, S_OUT_RD, S_OUT_CHK, S_IN_RD, S_IN_D, S_IN_SQ,
    S_IN_CMP, S_REDIR, S_DROP, S_CP_RD, S_CP_GR, S_CP_WR, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CW-1:0] n_r, n_nxt, next_r, next_nxt, kept_r, kept_nxt;
  logic          pv_r, pv_nxt, brk_r, brk_nxt;
  logic [IW-1:0] pk_r, pk_nxt, from_r, from_nxt, to_r, to_nxt, r_r, r_nxt;
  logic [CB-1:0] pix_r, pix_nxt, piy_r, piy_nxt, piz_r, piz_nxt;
  logic          piref_r, piref_nxt, pjref_r, pjref_nxt;
  logic [CB:0]   dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [SQW-1:0] sqx_r, sqx_nxt, sqy_r, sqy_nxt, sqz_r, sqz_nxt;
  logic [TOL_W-1:0] tol_r, tol_nxt;
  logic          drop_r, drop_nxt, done_once_r, done_once_nxt;
  logic [SLOT_W-1:0] qslot_r, qslot_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  // RAM ports
  logic           c_we;  logic [IW-1:0] c_wa, c_ra; logic [CRW-1:0] c_wd, c_rd;
  logic           m_we;  logic [IW-1:0] m_wa, m_ra; logic           m_wd, m_rd;
  logic           t_we;  logic [IW-1:0] t_wa, t_ra; logic [IW-1:0]  t_wd, t_rd;
  logic           g_we;  logic [IW-1:0] g_wa, g_ra; logic [GW-1:0]  g_wd, g_rd;
  logic           p_we;  logic [IW-1:0] p_wa, p_ra; logic [IW:0]    p_wd, p_rd;
  logic           s_we;  logic [IW-1:0] s_wa, s_ra; logic [IW-1:0]  s_wd, s_rd;

  cpm_ram #(.WIDTH(CRW), .DEPTH(MAX_POINTS)) u_coord (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  cpm_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_merged (
    .clk, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  cpm_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_target (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  cpm_ram #(.WIDTH(GW), .DEPTH(MAX_POINTS)) u_group (
    .clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  cpm_ram #(.WIDTH(IW + 1), .DEPTH(MAX_POINTS)) u_compact (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  cpm_ram #(.WIDTH(IW), .DEPTH(MAX_POINTS)) u_rep (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  logic          in_accept, out_free, in_range, q_in_range, close, keep;
  logic [CB:0]   mag_x, mag_y, mag_z;
  logic [SUMW-1:0] dist_sum;
  logic [IW-1:0] new_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_range  = 32'(in_data.slot) < 32'(MAX_POINTS);
  assign q_in_range = 32'(qslot_r) < 32'(MAX_POINTS);

  // Distance math: absolute differences, squares and the tolerance compare.
  assign mag_x = dx_r[CB] ? (~dx_r + 1'b1) : dx_r;
  assign mag_y = dy_r[CB] ? (~dy_r + 1'b1) : dy_r;
  assign mag_z = dz_r[CB] ? (~dz_r + 1'b1) : dz_r;
  assign dist_sum = SUMW'(sqx_r) + SUMW'(sqy_r) + SUMW'(sqz_r);
  assign close = (tol_r == '0) ? (dist_sum == '0)
                               : (CMPW'(dist_sum) < CMPW'(tol_r));
  // group entry: used flag, seen flag, assigned new index
  assign keep    = !drop_r || g_rd[IW+1];
  assign new_idx = g_rd[IW] ? g_rd[IW-1:0] : IW'(next_r);

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; n_nxt = n_r;
    next_nxt = next_r; kept_nxt = kept_r;
    pv_nxt = pv_r; brk_nxt = brk_r; pk_nxt = pk_r;
    from_nxt = from_r; to_nxt = to_r; r_nxt = r_r;
    pix_nxt = pix_r; piy_nxt = piy_r; piz_nxt = piz_r;
    piref_nxt = piref_r; pjref_nxt = pjref_r;
    dx_nxt = dx_r; dy_nxt = dy_r; dz_nxt = dz_r;
    sqx_nxt = sqx_r; sqy_nxt = sqy_r; sqz_nxt = sqz_r;
    tol_nxt = tol_r; drop_nxt = drop_r; done_once_nxt = done_once_r;
    qslot_nxt = qslot_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;

    c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
    m_we = 1'b0; m_wa = '0; m_wd = 1'b0; m_ra = '0;
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0;
    p_ra = IW'(qslot_r);
    s_ra = IW'(qslot_r);

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOLERANCE: tol_nxt = cfg_data;
        CFG_DROP:      drop_nxt = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        p_ra = IW'(in_data.slot);
        s_ra = IW'(in_data.slot);
        if (in_accept) begin
          if (in_data.opcode == OP_LOAD) begin
            if (in_range) begin
              c_we = 1'b1;
              c_wa = IW'(in_data.slot);
              c_wd = {in_data.referenced, in_data.coord_z[CB-1:0],
                      in_data.coord_y[CB-1:0], in_data.coord_x[CB-1:0]};
              n_nxt = CW'(in_data.slot) + CW'(1);
            end
            if (in_data.final_point) begin
              k_nxt = '0;
              state_nxt = S_INIT;
            end
          end else begin
            qslot_nxt = in_data.slot;
            state_nxt = S_QRESP;
          end
        end
      end
      S_QRESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '0;
          out_data_nxt.answer_kind = KIND_QUERY;
          if (done_once_r && q_in_range && p_rd[IW]) begin
            out_data_nxt.mapped_valid = 1'b1;
            out_data_nxt.mapped_index = SLOT_W'(p_rd[IW-1:0]);
          end
          if (32'(qslot_r) < 32'(kept_r)) begin
            out_data_nxt.representative_valid = 1'b1;
            out_data_nxt.representative = SLOT_W'(s_rd);
          end
          out_data_nxt.surviving_count = COUNT_W'(kept_r);
          state_nxt = S_IDLE;
        end
      end
      // Clear every entry of the merge marks, identity map, groups and compaction map.
      S_INIT: begin
        m_we = 1'b1; m_wa = IW'(k_r); m_wd = 1'b0;
        t_we = 1'b1; t_wa = IW'(k_r); t_wd = IW'(k_r);
        g_we = 1'b1; g_wa = IW'(k_r); g_wd = '0;
        p_we = 1'b1; p_wa = IW'(k_r); p_wd = '0;
        if (k_r == CW'(MAX_POINTS - 1)) begin
          i_nxt = '0;
          state_nxt = S_OUT_RD;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_OUT_RD: begin
        if (i_r >= n_r) begin
          i_nxt = '0;
          next_nxt = '0;
          k_nxt = '0;
          pv_nxt = 1'b0;
          state_nxt = drop_r ? S_DROP : S_CP_RD;
        end else begin
          c_ra = IW'(i_r);
          m_ra = IW'(i_r);
          state_nxt = S_OUT_CHK;
        end
      end
      S_OUT_CHK: begin
        if (m_rd) begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_OUT_RD;
        end else begin
          {piref_nxt, piz_nxt, piy_nxt, pix_nxt} = c_rd;
          j_nxt = i_r + 1'b1;
          state_nxt = S_IN_RD;
        end
      end
      S_IN_RD: begin
        if (j_r >= n_r) begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_OUT_RD;
        end else begin
          c_ra = IW'(j_r);
          m_ra = IW'(j_r);
          state_nxt = S_IN_D;
        end
      end
      S_IN_D: begin
        if (m_rd) begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_IN_RD;
        end else begin
          dx_nxt = {pix_r[CB-1], pix_r} - {c_rd[CB-1], c_rd[CB-1:0]};
          dy_nxt = {piy_r[CB-1], piy_r} - {c_rd[2*CB-1], c_rd[2*CB-1:CB]};
          dz_nxt = {piz_r[CB-1], piz_r} - {c_rd[3*CB-1], c_rd[3*CB-1:2*CB]};
          pjref_nxt = c_rd[3*CB];
          state_nxt = S_IN_SQ;
        end
      end
      S_IN_SQ: begin
        sqx_nxt = SQW'(mag_x) * SQW'(mag_x);
        sqy_nxt = SQW'(mag_y) * SQW'(mag_y);
        sqz_nxt = SQW'(mag_z) * SQW'(mag_z);
        state_nxt = S_IN_CMP;
      end
      S_IN_CMP: begin
        if (!close) begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_IN_RD;
        end else begin
          m_we = 1'b1;
          m_wd = 1'b1;
          k_nxt = '0;
          pv_nxt = 1'b0;
          state_nxt = S_REDIR;
          if (pjref_r && !piref_r) begin
            // referenced later point wins: earlier group follows it
            m_wa = IW'(i_r);
            from_nxt = IW'(i_r);
            to_nxt = IW'(j_r);
            brk_nxt = 1'b1;
          end else begin
            m_wa = IW'(j_r);
            from_nxt = IW'(j_r);
            to_nxt = IW'(i_r);
            brk_nxt = 1'b0;
          end
        end
      end
      // Rescan the target map, rewriting entries that point at the loser.
      S_REDIR: begin
        t_ra = IW'(k_r);
        if (pv_r && (t_rd == from_r)) begin
          t_we = 1'b1; t_wa = pk_r; t_wd = to_r;
        end
        if (k_r < n_r) begin
          pk_nxt = IW'(k_r);
          pv_nxt = 1'b1;
          k_nxt = k_r + 1'b1;
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            if (brk_r) begin
              i_nxt = i_r + 1'b1;
              state_nxt = S_OUT_RD;
            end else begin
              j_nxt = j_r + 1'b1;
              state_nxt = S_IN_RD;
            end
          end
        end
      end
      // Mark groups that hold a referenced member.
      S_DROP: begin
        t_ra = IW'(k_r);
        c_ra = IW'(k_r);
        if (pv_r && c_rd[3*CB]) begin
          g_we = 1'b1; g_wa = t_rd; g_wd = {1'b1, 1'b0, {IW{1'b0}}};
        end
        if (k_r < n_r) begin
          pv_nxt = 1'b1;
          k_nxt = k_r + 1'b1;
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            state_nxt = S_CP_RD;
          end
        end
      end
      S_CP_RD: begin
        if (i_r >= n_r) begin
          kept_nxt = next_r;
          state_nxt = S_DONE;
        end else begin
          t_ra = IW'(i_r);
          state_nxt = S_CP_GR;
        end
      end
      S_CP_GR: begin
        g_ra = t_rd;
        r_nxt = t_rd;
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        if (keep) begin
          if (!g_rd[IW]) begin
            g_we = 1'b1; g_wa = r_r; g_wd = {g_rd[IW+1], 1'b1, IW'(next_r)};
            s_we = 1'b1; s_wa = IW'(next_r); s_wd = r_r;
            next_nxt = next_r + 1'b1;
          end
          p_we = 1'b1; p_wa = IW'(i_r); p_wd = {1'b1, new_idx};
        end
        i_nxt = i_r + 1'b1;
        state_nxt = S_CP_RD;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '0;
          out_data_nxt.answer_kind = KIND_REPORT;
          out_data_nxt.surviving_count = COUNT_W'(kept_r);
          done_once_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      kept_r      <= '0;
      pv_r        <= 1'b0;
      tol_r       <= '0;
      drop_r      <= 1'b0;
      done_once_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      kept_r      <= kept_nxt;
      pv_r        <= pv_nxt;
      tol_r       <= tol_nxt;
      drop_r      <= drop_nxt;
      done_once_r <= done_once_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; next_r <= next_nxt;
    brk_r <= brk_nxt; pk_r <= pk_nxt; from_r <= from_nxt; to_r <= to_nxt;
    r_r <= r_nxt; pix_r <= pix_nxt; piy_r <= piy_nxt; piz_r <= piz_nxt;
    piref_r <= piref_nxt; pjref_r <= pjref_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; dz_r <= dz_nxt;
    sqx_r <= sqx_nxt; sqy_r <= sqy_nxt; sqz_r <= sqz_nxt;
    qslot_r <= qslot_nxt; out_data_r <= out_data_nxt;
  end

  // At the end of a merge the survivor count never exceeds the points loaded.
  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> kept_r <= n_r)
    else $error("surviving count exceeds loaded points");

  // A redirect always moves a group onto a different point.
  a_redir_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REDIR) |-> from_r != to_r)
    else $error("redirect with identical source and destination");

  // Compaction only hands out new indexes below the point count.
  a_new_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CP_WR && keep && !g_rd[IW]) |-> next_r < n_r)
    else $error("new index out of range");

endmodule

`default_nettype wire

FILE: verif/tb_coincident_point_merger_core.sv
// ----------------------------------------------------------------------------
// tb_coincident_point_merger_core
// Self-checking bench for the coincident point merger. Loads point sets,
// triggers the weld pass, reads back index and representative tables, and
// compares every result against an in-bench model of the merge rules.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_coincident_point_merger_core;
  import cpm_pkg::*;

  localparam int NPTS      = DEF_MAX_POINTS;
  localparam int IDLE_LIMIT = 100000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TOL_W-1:0] cfg_data;

  coincident_point_merger_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model state: point table, weld results and register copies
  longint px[NPTS], py[NPTS], pz[NPTS];
  bit pref[NPTS];
  int loaded_n;
  int kept_n;
  bit new_ok[NPTS];
  int new_idx[NPTS];
  int rep_idx[NPTS];
  logic [TOL_W-1:0] tol_sq;
  bit drop_unref;

  out_item_t pending_answers[$];
  int err_count;
  int sent_items;
  bit quiet;        // no idling on either side
  int hold_len;     // long receiver hold-off request

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Squared distance test, exact over 66 bits.
  function automatic bit close_pair(int a, int b);
    logic [32:0] m;
    logic [65:0] acc;
    longint d[3];
    d[0] = px[a] - px[b];
    d[1] = py[a] - py[b];
    d[2] = pz[a] - pz[b];
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      m = (d[c] < 0) ? 33'(-d[c]) : 33'(d[c]);
      acc = acc + ({33'b0, m} * {33'b0, m});
    end
    if (tol_sq == '0) return acc == '0;
    return acc < {2'b00, tol_sq};
  endfunction

  // Greedy weld, optional drop of unreferenced groups, then compaction.
  function automatic void weld_points();
    bit gone[NPTS];
    int tgt[NPTS];
    bit used[NPTS];
    bit seen[NPTS];
    int root_to_new[NPTS];
    int n;
    int nxt;
    int r;
    n = loaded_n;
    nxt = 0;
    for (int i = 0; i < NPTS; i++) begin
      gone[i] = 0; tgt[i] = i; used[i] = 0; seen[i] = 0; root_to_new[i] = 0;
      new_ok[i] = 0; new_idx[i] = 0; rep_idx[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      if (!gone[i]) begin
        for (int j = i + 1; j < n; j++) begin
          if (!gone[j] && close_pair(i, j)) begin
            if (pref[j] && !pref[i]) begin
              // referenced point wins; earlier group follows it
              gone[i] = 1;
              for (int k = 0; k < n; k++) if (tgt[k] == i) tgt[k] = j;
              break;
            end
            gone[j] = 1;
            for (int k = 0; k < n; k++) if (tgt[k] == j) tgt[k] = i;
          end
        end
      end
    end
    if (drop_unref)
      for (int i = 0; i < n; i++) if (pref[i]) used[tgt[i]] = 1;
    for (int i = 0; i < n; i++) begin
      r = tgt[i];
      if (!(drop_unref && !used[r])) begin
        if (!seen[r]) begin
          seen[r] = 1;
          root_to_new[r] = nxt;
          rep_idx[nxt] = r;
          nxt++;
        end
        new_ok[i] = 1;
        new_idx[i] = root_to_new[r];
      end
    end
    kept_n = nxt;
  endfunction

  // Apply one accepted transaction to the model; queue its answer if any.
  function automatic void predict_item(in_item_t it);
    out_item_t ans;
    int s;
    ans = '0;
    s = int'(it.slot);
    if (it.opcode == OP_LOAD) begin
      px[s] = longint'(it.coord_x);
      py[s] = longint'(it.coord_y);
      pz[s] = longint'(it.coord_z);
      pref[s] = it.referenced;
      loaded_n = s + 1;
      if (!it.final_point) return;
      weld_points();
      ans.answer_kind = KIND_REPORT;
    end else begin
      ans.answer_kind = KIND_QUERY;
      if (new_ok[s]) begin
        ans.mapped_index = SLOT_W'(new_idx[s]);
        ans.mapped_valid = 1'b1;
      end
      if (s < kept_n) begin
        ans.representative = SLOT_W'(rep_idx[s]);
        ans.representative_valid = 1'b1;
      end
    end
    ans.surviving_count = COUNT_W'(kept_n);
    pending_answers.push_back(ans);
  endfunction

  // Offer one transaction, hold it until accepted. Valid stays high on return.
  task automatic send_item(in_item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
    sent_items++;
  endtask

  task automatic send_load(int s, int x, int y, int z, bit r, bit fin);
    in_item_t it;
    it = '0;
    it.opcode = OP_LOAD;
    it.slot = SLOT_W'(s);
    it.coord_x = x; it.coord_y = y; it.coord_z = z;
    it.referenced = r;
    it.final_point = fin;
    send_item(it);
  endtask

  task automatic send_query(int s);
    in_item_t it;
    it = '0;
    it.opcode = OP_QUERY;
    it.slot = SLOT_W'(s);
    // junk in the unused fields must not matter
    it.coord_x = $urandom; it.coord_y = $urandom; it.coord_z = $urandom;
    it.referenced = 1'($urandom_range(0, 1));
    it.final_point = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // Drop valid and wait until every answer is back and the block is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TOLERANCE) tol_sq = val;
    else drop_unref = val[0];
  endtask

  // Random point set of n points, most near four centers, some anywhere, then queries.
  task automatic run_point_set(int n, int n_queries);
    int cx[4], cy[4], cz[4];
    int c, spread;
    for (int k = 0; k < 4; k++) begin
      cx[k] = $urandom; cy[k] = $urandom; cz[k] = $urandom;
    end
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
        0: spread = 0;
        1: spread = 3;
        2: spread = 1 << $urandom_range(4, 20);
        default: spread = -1;
      endcase
      if (spread < 0)
        send_load(i, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                  i == n - 1);
      else
        send_load(i, cx[c] + $urandom_range(0, 2 * spread) - spread,
                  cy[c] + $urandom_range(0, 2 * spread) - spread,
                  cz[c] + $urandom_range(0, 2 * spread) - spread,
                  $urandom_range(0, 2) != 0, i == n - 1);
    end
    for (int q = 0; q < n_queries; q++)
      send_query(($urandom_range(0, 9) == 0) ? $urandom_range(0, NPTS - 1)
                                              : $urandom_range(0, n + 2));
  endtask

  // Queries right after reset see cleared tables.
  task automatic test_query_before_merge();
    send_query(0);
    send_query(NPTS - 1);
    send_query(5);
  endtask

  // Hand-built sets covering the weld rules and field extremes.
  task automatic test_directed_welds();
    write_reg(CFG_TOLERANCE, '0);
    write_reg(CFG_DROP, 64'd0);
    // top slot loaded without a final: never read by the weld pass
    send_load(NPTS - 1, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b1, 1'b0);
    send_load(0, 0, 0, 0, 1'b0, 1'b0);
    send_load(1, 0, 0, 0, 1'b1, 1'b0);          // referenced wins over earlier
    send_load(2, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0);
    send_load(3, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 1'b0);
    send_load(4, 0, 0, 0, 1'b0, 1'b0);          // joins the referenced one
    send_load(5, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b1);
    for (int s = 0; s < 7; s++) send_query(s);
    send_query(NPTS - 1);
    // everything welds with the widest tolerance; drop unreferenced groups
    write_reg(CFG_TOLERANCE, '1);
    write_reg(CFG_DROP, 64'd1);
    send_load(0, 1, 2, 3, 1'b0, 1'b0);
    send_load(1, 1, 2, 4, 1'b0, 1'b0);
    send_load(2, 1, 2, 5, 1'b0, 1'b1);
    send_query(0);
    send_query(1);
  endtask

  // Random sets across a sweep of register settings.
  task automatic test_random_sets();
    logic [TOL_W-1:0] tol_choice[6];
    int n;
    tol_choice[0] = '0;
    tol_choice[1] = 64'd16;
    tol_choice[2] = 64'd1 << 40;
    tol_choice[3] = '1;
    tol_choice[4] = 64'd1;
    tol_choice[5] = {$urandom, $urandom};
    while (sent_items < 600) begin
      write_reg(CFG_TOLERANCE, tol_choice[$urandom_range(0, 5)]);
      write_reg(CFG_DROP, 64'($urandom_range(0, 1)));
      for (int k = 0; k < 3; k++) begin
        n = ($urandom_range(0, 15) == 0) ? 48 : $urandom_range(1, 16);
        run_point_set(n, $urandom_range(1, n + 3));
      end
    end
  endtask

  // Receiver holds off long enough that the output register fills and the
  // input stalls while queries keep coming.
  task automatic test_backpressure();
    drain();
    hold_len = 300;
    for (int q = 0; q < 20; q++) send_query($urandom_range(0, 15));
    drain();
  endtask

  // Closing stretch at full rate, no idling anywhere.
  task automatic test_full_rate();
    drain();
    quiet = 1'b1;
    for (int k = 0; k < 4; k++) run_point_set($urandom_range(4, 12), 10);
  endtask

  // Receiver side: random stall bursts, calm stretches, the long hold-off.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check each result against the oldest expected answer.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result transaction %p", out_data);
        err_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_data.answer_kind !== want.answer_kind) begin
          $error("answer_kind exp %0d got %0d", want.answer_kind, out_data.answer_kind);
          err_count++;
        end
        if (out_data.mapped_index !== want.mapped_index) begin
          $error("mapped_index exp %0d got %0d", want.mapped_index, out_data.mapped_index);
          err_count++;
        end
        if (out_data.mapped_valid !== want.mapped_valid) begin
          $error("mapped_valid exp %0d got %0d", want.mapped_valid, out_data.mapped_valid);
          err_count++;
        end
        if (out_data.representative !== want.representative) begin
          $error("representative exp %0d got %0d", want.representative,
                 out_data.representative);
          err_count++;
        end
        if (out_data.representative_valid !== want.representative_valid) begin
          $error("representative_valid exp %0d got %0d", want.representative_valid,
                 out_data.representative_valid);
          err_count++;
        end
        if (out_data.surviving_count !== want.surviving_count) begin
          $error("surviving_count exp %0d got %0d", want.surviving_count,
                 out_data.surviving_count);
          err_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on any channel.
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_count = 0;
    sent_items = 0;
    quiet = 1'b0;
    hold_len = 0;
    loaded_n = 0;
    kept_n = 0;
    tol_sq = '0;
    drop_unref = 1'b0;
    for (int i = 0; i < NPTS; i++) begin
      px[i] = 0; py[i] = 0; pz[i] = 0; pref[i] = 0;
      new_ok[i] = 0; new_idx[i] = 0; rep_idx[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_query_before_merge();
    test_directed_welds();
    test_random_sets();
    test_backpressure();
    test_full_rate();

    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0 && pending_answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
